/* hdl/arpc_pkg.sv */
package arpc_pkg;

    // Default table depth
    localparam int TABLE_ENTRIES_DEF = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 48;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_IP  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_MAC = 1'b1;

    // Input operation codes
    localparam logic OP_RESOLVE = 1'b0;
    localparam logic OP_PACKET  = 1'b1;

    // Received ARP operation that asks for a reply
    localparam logic [15:0] ARP_OPC_REQUEST = 16'd1;

    // Frame kinds on the result
    localparam logic [1:0] SEND_NONE    = 2'd0;
    localparam logic [1:0] SEND_REQUEST = 2'd1;
    localparam logic [1:0] SEND_REPLY   = 2'd2;

    // ARP opcodes of emitted frames
    localparam logic [1:0] ARP_OP_NONE    = 2'd0;
    localparam logic [1:0] ARP_OP_REQUEST = 2'd1;
    localparam logic [1:0] ARP_OP_REPLY   = 2'd2;

    // Ethernet broadcast address
    localparam logic [47:0] BCAST_MAC = {6{8'hff}};

    typedef struct packed {
        logic        op;
        logic [31:0] query_ip;
        logic [31:0] sender_ip;
        logic [47:0] sender_mac;
        logic [15:0] arp_opcode;
    } in_item_t;

    typedef struct packed {
        logic        hit;
        logic [47:0] found_mac;
        logic [1:0]  send_kind;
        logic [47:0] frame_dest_mac;
        logic [1:0]  arp_op_out;
        logic [47:0] target_mac_out;
        logic [31:0] target_ip_out;
    } out_item_t;

    // One cache entry as stored in the table memory
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
    } entry_t;

endpackage

/* hdl/arpc_table.sv */
module arpc_table #(
    parameter int ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(ENTRIES)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output arpc_pkg::entry_t     rd_data,
    output logic                 rd_valid,
    input  logic                 wr_en,
    input  logic [IDX_W-1:0]     wr_addr,
    input  arpc_pkg::entry_t     wr_data
);

    arpc_pkg::entry_t mem [ENTRIES];
    arpc_pkg::entry_t rd_data_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: cleared at reset, set on every write, sampled with the read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

/* hdl/arpc_ctrl.sv */
module arpc_ctrl #(
    parameter int ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = $clog2(ENTRIES),
    localparam int CNT_W = $clog2(ENTRIES + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  arpc_pkg::in_item_t   in_item,
    output logic                 busy,
    output logic                 done,
    output arpc_pkg::out_item_t  result,
    output logic                 rd_en,
    output logic [IDX_W-1:0]     rd_addr,
    input  arpc_pkg::entry_t     rd_data,
    input  logic                 rd_valid,
    output logic                 wr_en,
    output logic [IDX_W-1:0]     wr_addr,
    output arpc_pkg::entry_t     wr_data
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t              state_reg, state_next;
    arpc_pkg::in_item_t  item_reg, item_next;
    logic [CNT_W-1:0]    rd_cnt_reg, rd_cnt_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    logic                match_reg, match_next;
    logic [IDX_W-1:0]    match_idx_reg, match_idx_next;
    logic [47:0]         match_mac_reg, match_mac_next;
    logic                free_found_reg, free_found_next;
    logic [IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]    victim_reg, victim_next;
    logic                done_reg, done_next;
    arpc_pkg::out_item_t result_reg, result_next;
    logic [31:0]         key_ip;

    // Resolve searches for the queried IP, a packet for the sender IP
    assign key_ip = (item_reg.op == arpc_pkg::OP_RESOLVE) ? item_reg.query_ip
                                                          : item_reg.sender_ip;

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        rd_cnt_next     = rd_cnt_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        match_next      = match_reg;
        match_idx_next  = match_idx_reg;
        match_mac_next  = match_mac_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        victim_next     = victim_reg;
        done_next       = 1'b0;
        result_next     = result_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_cnt_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = victim_reg;
        wr_data.ip      = item_reg.sender_ip;
        wr_data.mac     = item_reg.sender_mac;

        case (state_reg)
            ST_IDLE:
            begin
                // Take a new transaction and restart the scan
                if (start)
                begin
                    item_next       = in_item;
                    rd_cnt_next     = '0;
                    match_next      = 1'b0;
                    free_found_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // Issue one table read per cycle
                if (rd_cnt_reg < CNT_W'(ENTRIES))
                begin
                    rd_en       = 1'b1;
                    rd_cnt_next = rd_cnt_reg + CNT_W'(1);
                end
                cmp_vld_next = rd_en;
                cmp_idx_next = rd_cnt_reg[IDX_W-1:0];

                // Compare the entry read in the previous cycle
                if (cmp_vld_reg)
                begin
                    if (rd_valid && (rd_data.ip == key_ip))
                    begin
                        match_next     = 1'b1;
                        match_idx_next = cmp_idx_reg;
                        match_mac_next = rd_data.mac;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        // Remember the lowest free slot
                        if (!rd_valid && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = cmp_idx_reg;
                        end
                        if (cmp_idx_reg == IDX_W'(ENTRIES - 1))
                        begin
                            state_next = ST_FINISH;
                        end
                    end
                end
            end
            ST_FINISH:
            begin
                state_next  = ST_IDLE;
                done_next   = 1'b1;
                result_next = '0;
                if (item_reg.op == arpc_pkg::OP_RESOLVE)
                begin
                    // Hit returns the MAC, miss broadcasts a request
                    if (match_reg)
                    begin
                        result_next.hit       = 1'b1;
                        result_next.found_mac = match_mac_reg;
                    end
                    else
                    begin
                        result_next.send_kind      = arpc_pkg::SEND_REQUEST;
                        result_next.frame_dest_mac = arpc_pkg::BCAST_MAC;
                        result_next.arp_op_out     = arpc_pkg::ARP_OP_REQUEST;
                        result_next.target_ip_out  = item_reg.query_ip;
                    end
                end
                else
                begin
                    // Learn the sender: matching entry, free slot, else victim
                    wr_en = 1'b1;
                    if (match_reg)
                    begin
                        wr_addr = match_idx_reg;
                    end
                    else if (free_found_reg)
                    begin
                        wr_addr = free_idx_reg;
                    end
                    else
                    begin
                        wr_addr     = victim_reg;
                        victim_next = (victim_reg == IDX_W'(ENTRIES - 1)) ? '0
                                    : victim_reg + IDX_W'(1);
                    end
                    // Answer a received request
                    if (item_reg.arp_opcode == arpc_pkg::ARP_OPC_REQUEST)
                    begin
                        result_next.send_kind      = arpc_pkg::SEND_REPLY;
                        result_next.frame_dest_mac = item_reg.sender_mac;
                        result_next.arp_op_out     = arpc_pkg::ARP_OP_REPLY;
                        result_next.target_mac_out = item_reg.sender_mac;
                        result_next.target_ip_out  = item_reg.sender_ip;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rd_cnt_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            victim_reg     <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_cnt_reg     <= rd_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            victim_reg     <= victim_next;
            done_reg       <= done_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        cmp_idx_reg   <= cmp_idx_next;
        match_idx_reg <= match_idx_next;
        match_mac_reg <= match_mac_next;
        free_idx_reg  <= free_idx_next;
        result_reg    <= result_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hdl/arp_cache_resolver.sv */
// ARP cache with request and reply generation.
// Input: present an item on in_item with start high; it is taken at a clock
// edge where start is high and busy is low. op selects a resolve of query_ip
// or a received ARP packet that learns sender_ip/sender_mac.
// Output: every transaction gives one result on result, marked by done for
// exactly one cycle. The receiver cannot stall, so it must take it then.
// Scan: the table is scanned one entry per cycle out of a memory with a
// registered read. A hit ends the scan at the matching entry; a miss or any
// learn without a match scans every entry. The next start is taken in the
// cycle done is high, so a new transaction is taken only once the last one
// has given its result.
// Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 own IP,
// 1 own MAC). Write only while the block is idle; the block leaves it unchecked.
// Reset: all entries become invalid and the replacement pointer returns to
// entry 0; no result is pending after reset.
module arp_cache_resolver #(
    parameter int TABLE_ENTRIES = arpc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  arpc_pkg::in_item_t                  in_item,
    output logic                                busy,
    output logic                                done,
    output arpc_pkg::out_item_t                 result,
    input  logic                                cfg_wr_en,
    input  logic [arpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [arpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    logic [31:0]       own_ip_reg;
    logic [47:0]       own_mac_reg;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    arpc_pkg::entry_t  rd_data;
    logic              rd_valid;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    arpc_pkg::entry_t  wr_data;

    // Station addresses, written by the configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                arpc_pkg::CFG_OWN_IP:  own_ip_reg  <= cfg_data[31:0];
                arpc_pkg::CFG_OWN_MAC: own_mac_reg <= cfg_data[47:0];
                default:
                begin
                    own_ip_reg <= own_ip_reg;
                end
            endcase
        end
    end

    arpc_ctrl #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .in_item  (in_item),
        .busy     (busy),
        .done     (done),
        .result   (result),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

    arpc_table #(
        .ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .rd_valid (rd_valid),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data)
    );

endmodule

/* hdl/arpc_checker.sv */
module arpc_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  logic                 done,
    input  arpc_pkg::out_item_t  result
);

    // An accepted transaction keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // A result is a single-cycle strobe and comes only when idle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy ##1 !done))
        else $error("done not a single idle-cycle strobe");

    // A hit emits no frame
    a_hit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.hit) |-> (result.send_kind == arpc_pkg::SEND_NONE))
        else $error("hit result carries a frame");

    // A request goes to broadcast with an empty target MAC
    a_request_form: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.send_kind == arpc_pkg::SEND_REQUEST))
        |-> ((result.frame_dest_mac == arpc_pkg::BCAST_MAC)
             && (result.arp_op_out == arpc_pkg::ARP_OP_REQUEST)
             && (result.target_mac_out == '0) && !result.hit))
        else $error("malformed ARP request result");

endmodule

bind arp_cache_resolver arpc_checker u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
